// ----- sv/pgs_pkg.sv -----
package pgs_pkg;

  localparam int UNIFORM_BITS_DEF = 32;
  localparam int SAMPLE_BITS_DEF  = 32;
  localparam int FRAC_BITS_DEF    = 28;

  // ln 2 in Q0.32
  localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

  // one result bit per stage
  localparam int SQRT_STEPS = 32;
  localparam int LOG_STEPS  = 32;
  // quotient of v << j << 31 by the root stays below 2^33
  localparam int DIV_STEPS  = 33;

endpackage

// ----- sv/polar_gaussian_sampler_unit.sv -----
// Polar-method normal sampler. Each pair of uniforms taken on start (while busy is low) maps to
// v1, v2 in [-1,1); pairs with w = v1^2 + v2^2 at or above 1, or equal to 0, are dropped with no
// output. Kept pairs give two Q4.28 samples on consecutive strobed cycles, v2*c first, then v1*c
// with out_last_of_pair set. The pipeline takes a pair every cycle while busy is low; the single
// result port sets the pace, since each kept pair occupies it for both samples, and busy rises
// while a second sample is pending and a finished pair waits behind it. The receiver cannot
// stall: results must be taken on the strobe.
module polar_gaussian_sampler_unit #(
  parameter int UNIFORM_BITS = pgs_pkg::UNIFORM_BITS_DEF,
  parameter int SAMPLE_BITS  = pgs_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS    = pgs_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [UNIFORM_BITS-1:0]       in_uniform_a,
  input  logic [UNIFORM_BITS-1:0]       in_uniform_b,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] out_normal_sample,
  output logic                          out_last_of_pair
);
  import pgs_pkg::*;

  localparam int ALIGN_R    = (UNIFORM_BITS > 32) ? UNIFORM_BITS - 32 : 0;
  localparam int ALIGN_L    = (UNIFORM_BITS < 32) ? 32 - UNIFORM_BITS : 0;
  localparam int NORM_STEPS = 6;
  localparam int RND_SHIFT  = 59 - FRAC_BITS;
  localparam logic [64:0] RND_HALF = 65'd1 << (58 - FRAC_BITS);
  localparam logic [64:0] SAT_NEG  = 65'd1 << (SAMPLE_BITS - 1);
  localparam logic [64:0] SAT_POS  = SAT_NEG - 65'd1;
  localparam logic [63:0] ONE_Q62  = 64'd1 << 62;

  typedef struct packed {
    logic        n1;
    logic        n2;
    logic [31:0] m1;
    logic [31:0] m2;
  } side_t;

  localparam int SIDE_BITS = $bits(side_t);

  function automatic logic [32:0] to_unit(input logic [UNIFORM_BITS-1:0] u);
    logic [31:0] a;
    a = 32'(u >> ALIGN_R) << ALIGN_L;
    // sign (negative flag) and magnitude of a - 2^31
    if (a[31]) begin
      return {1'b0, 1'b0, a[30:0]};
    end
    return {1'b1, 32'h8000_0000 - a};
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] finish(input logic [63:0] mag, input logic neg);
    logic [64:0] sum;
    logic [64:0] m;
    sum = {1'b0, mag} + RND_HALF;
    m = sum >> RND_SHIFT;
    if (neg) begin
      if (m > SAT_NEG) m = SAT_NEG;
      return SAMPLE_BITS'(~m + 65'd1);
    end
    if (m > SAT_POS) m = SAT_POS;
    return SAMPLE_BITS'(m);
  endfunction

  logic en;
  logic fv_r;
  logic pend_r;

  assign busy = pend_r && fv_r;
  assign en   = !busy;

  // stage 1: align and fold to sign and magnitude
  logic  v1_r;
  side_t side1_r;
  logic [32:0] ua;
  logic [32:0] ub;

  assign ua = to_unit(in_uniform_a);
  assign ub = to_unit(in_uniform_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r <= '{n1: ua[32], n2: ub[32], m1: ua[31:0], m2: ub[31:0]};
    end
  end

  // stage 2: squares
  logic        v2_r;
  side_t       side2_r;
  logic [63:0] sq1_r;
  logic [63:0] sq2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side2_r <= side1_r;
      sq1_r   <= 64'(side1_r.m1) * 64'(side1_r.m1);
      sq2_r   <= 64'(side1_r.m2) * 64'(side1_r.m2);
    end
  end

  // stage 3: w and reject test
  logic        v3_r;
  side_t       side3_r;
  logic [63:0] w3_r;
  logic [63:0] w_sum;

  assign w_sum = sq1_r + sq2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r && (w_sum != '0) && (w_sum < ONE_Q62);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3_r <= side2_r;
      w3_r    <= w_sum;
    end
  end

  // normalize: shift top set bit to bit 62, counting the shift in k
  logic [NORM_STEPS-1:0] nv_r;
  logic [63:0]           nw_r    [NORM_STEPS];
  logic [5:0]            nk_r    [NORM_STEPS];
  side_t                 nside_r [NORM_STEPS];

  genvar s;
  for (s = 0; s < NORM_STEPS; s++) begin : g_norm
    localparam int SH = 32 >> s;
    logic        cur_v;
    logic [63:0] cur_w;
    logic [5:0]  cur_k;
    side_t       cur_side;
    logic        zero_top;

    if (s == 0) begin : g_first
      assign cur_v    = v3_r;
      assign cur_w    = w3_r;
      assign cur_k    = '0;
      assign cur_side = side3_r;
    end else begin : g_next
      assign cur_v    = nv_r[s-1];
      assign cur_w    = nw_r[s-1];
      assign cur_k    = nk_r[s-1];
      assign cur_side = nside_r[s-1];
    end

    assign zero_top = cur_w[62 -: SH] == '0;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        nv_r[s] <= 1'b0;
      end else if (en) begin
        nv_r[s] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nw_r[s]    <= zero_top ? cur_w << SH : cur_w;
        nk_r[s]    <= zero_top ? cur_k + 6'(SH) : cur_k;
        nside_r[s] <= cur_side;
      end
    end
  end

  // log2 fraction and sqrt of w shifted by an even amount, side by side
  logic        lg_v;
  logic [31:0] lg_frac;
  logic [SIDE_BITS+5:0] lg_sb;
  logic        rt_v;
  logic [31:0] rt_root;
  logic [4:0]  rt_j;
  logic [5:0]  lg_k;
  side_t       lg_side;

  pgs_log #(
    .SB_BITS(SIDE_BITS + 6)
  ) u_log (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (nv_r[NORM_STEPS-1]),
    .in_x    (nw_r[NORM_STEPS-1][62:31]),
    .in_sb   ({nk_r[NORM_STEPS-1], nside_r[NORM_STEPS-1]}),
    .out_v   (lg_v),
    .out_frac(lg_frac),
    .out_sb  (lg_sb)
  );

  pgs_sqrt #(
    .SB_BITS(5)
  ) u_sqrt_w (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (nv_r[NORM_STEPS-1]),
    .in_rad  (nw_r[NORM_STEPS-1] >> nk_r[NORM_STEPS-1][0]),
    .in_sb   (nk_r[NORM_STEPS-1][5:1]),
    .out_v   (rt_v),
    .out_root(rt_root),
    .out_sb  (rt_j)
  );

  assign lg_k    = lg_sb[SIDE_BITS+5:SIDE_BITS];
  assign lg_side = lg_sb[SIDE_BITS-1:0];

  // A = k*2^32 - f split in halves; scaled magnitudes for the ratio
  logic        xa_v_r;
  logic [5:0]  xa_ahi_r;
  logic [31:0] xa_alo_r;
  logic [31:0] xa_q1_r;
  logic [31:0] xa_q2_r;
  logic [31:0] xa_den_r;
  logic [1:0]  xa_n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xa_v_r <= 1'b0;
    end else if (en) begin
      xa_v_r <= lg_v && rt_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xa_ahi_r <= (lg_frac != '0) ? lg_k - 6'd1 : lg_k;
      xa_alo_r <= ~lg_frac + 32'd1;
      xa_q1_r  <= lg_side.m1 << rt_j;
      xa_q2_r  <= lg_side.m2 << rt_j;
      xa_den_r <= rt_root;
      xa_n_r   <= {lg_side.n1, lg_side.n2};
    end
  end

  // L = A * ln2
  logic        lm_v_r;
  logic [37:0] lm_hi_r;
  logic [31:0] lm_lo_r;
  logic [1:0]  lm_n_r;
  logic [63:0] lo_prod;

  assign lo_prod = 64'(xa_alo_r) * 64'(LN2_Q32);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lm_v_r <= 1'b0;
    end else if (en) begin
      lm_v_r <= xa_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lm_hi_r <= 38'(xa_ahi_r) * 38'(LN2_Q32);
      lm_lo_r <= lo_prod[63:32];
      lm_n_r  <= xa_n_r;
    end
  end

  logic        ls_v_r;
  logic [38:0] ls_l_r;
  logic [1:0]  ls_n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ls_v_r <= 1'b0;
    end else if (en) begin
      ls_v_r <= lm_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ls_l_r <= 39'(lm_hi_r) + 39'(lm_lo_r);
      ls_n_r <= lm_n_r;
    end
  end

  // S = sqrt(2L) in Q.28
  logic        sq_v;
  logic [31:0] sq_root;
  logic [1:0]  sq_n;

  pgs_sqrt #(
    .SB_BITS(2)
  ) u_sqrt_l (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (ls_v_r),
    .in_rad  (64'(ls_l_r) << 25),
    .in_sb   (ls_n_r),
    .out_v   (sq_v),
    .out_root(sq_root),
    .out_sb  (sq_n)
  );

  // |v| / sqrt(w), same latency as the L path
  logic [31:0] p1;
  logic [31:0] p2;

  pgs_div u_div_1 (
    .clk      (clk),
    .en       (en),
    .in_num   (xa_q1_r),
    .in_den   (xa_den_r),
    .out_ratio(p1)
  );

  pgs_div u_div_2 (
    .clk      (clk),
    .en       (en),
    .in_num   (xa_q2_r),
    .in_den   (xa_den_r),
    .out_ratio(p2)
  );

  // products
  logic        pv_r;
  logic [63:0] prod1_r;
  logic [63:0] prod2_r;
  logic [1:0]  pn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (en) begin
      pv_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod1_r <= 64'(p1) * 64'(sq_root);
      prod2_r <= 64'(p2) * 64'(sq_root);
      pn_r    <= sq_n;
    end
  end

  // round, sign and saturate
  logic [SAMPLE_BITS-1:0] fin1_r;
  logic [SAMPLE_BITS-1:0] fin2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (en) begin
      fv_r <= pv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin1_r <= finish(prod1_r, pn_r[1]);
      fin2_r <= finish(prod2_r, pn_r[0]);
    end
  end

  // output: v2 sample first, v1 sample held for the following cycle
  logic                   out_valid_r;
  logic                   out_last_r;
  logic [SAMPLE_BITS-1:0] out_sample_r;
  logic [SAMPLE_BITS-1:0] second_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (pend_r) begin
      out_valid_r <= 1'b1;
      pend_r      <= 1'b0;
    end else if (fv_r) begin
      out_valid_r <= 1'b1;
      pend_r      <= 1'b1;
    end else begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r) begin
      out_sample_r <= second_r;
      out_last_r   <= 1'b1;
    end else begin
      out_sample_r <= fin2_r;
      out_last_r   <= 1'b0;
      second_r     <= fin1_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_normal_sample = $signed(out_sample_r);
  assign out_last_of_pair  = out_last_r;

endmodule

// ----- sv/pgs_sqrt.sv -----
module pgs_sqrt #(
  parameter int SB_BITS = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_v,
  input  logic [63:0]        in_rad,
  input  logic [SB_BITS-1:0] in_sb,
  output logic               out_v,
  output logic [31:0]        out_root,
  output logic [SB_BITS-1:0] out_sb
);
  import pgs_pkg::*;

  logic [SQRT_STEPS-1:0] v_r;
  logic [63:0]           rad_r  [SQRT_STEPS];
  logic [32:0]           rem_r  [SQRT_STEPS];
  logic [31:0]           root_r [SQRT_STEPS];
  logic [SB_BITS-1:0]    sb_r   [SQRT_STEPS];

  genvar i;
  for (i = 0; i < SQRT_STEPS; i++) begin : g_step
    logic               cur_v;
    logic [63:0]        cur_rad;
    logic [32:0]        cur_rem;
    logic [31:0]        cur_root;
    logic [SB_BITS-1:0] cur_sb;
    logic [34:0]        rem_sh;
    logic [34:0]        trial;
    logic               fits;

    if (i == 0) begin : g_first
      assign cur_v    = in_v;
      assign cur_rad  = in_rad;
      assign cur_rem  = '0;
      assign cur_root = '0;
      assign cur_sb   = in_sb;
    end else begin : g_next
      assign cur_v    = v_r[i-1];
      assign cur_rad  = rad_r[i-1];
      assign cur_rem  = rem_r[i-1];
      assign cur_root = root_r[i-1];
      assign cur_sb   = sb_r[i-1];
    end

    // bring down two radicand bits, try root*4+1
    assign rem_sh = {cur_rem, cur_rad[63:62]};
    assign trial  = {1'b0, cur_root, 2'b01};
    assign fits   = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[i]  <= {cur_rad[61:0], 2'b00};
        rem_r[i]  <= 33'(fits ? rem_sh - trial : rem_sh);
        root_r[i] <= {cur_root[30:0], fits};
        sb_r[i]   <= cur_sb;
      end
    end
  end

  assign out_v    = v_r[SQRT_STEPS-1];
  assign out_root = root_r[SQRT_STEPS-1];
  assign out_sb   = sb_r[SQRT_STEPS-1];

endmodule

// ----- sv/pgs_log.sv -----
module pgs_log #(
  parameter int SB_BITS = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_v,
  input  logic [31:0]        in_x,
  input  logic [SB_BITS-1:0] in_sb,
  output logic               out_v,
  output logic [31:0]        out_frac,
  output logic [SB_BITS-1:0] out_sb
);
  import pgs_pkg::*;

  logic [LOG_STEPS-1:0] v_r;
  logic [31:0]          z_r  [LOG_STEPS];
  logic [31:0]          f_r  [LOG_STEPS];
  logic [SB_BITS-1:0]   sb_r [LOG_STEPS];

  genvar i;
  for (i = 0; i < LOG_STEPS; i++) begin : g_step
    logic               cur_v;
    logic [31:0]        cur_z;
    logic [31:0]        cur_f;
    logic [SB_BITS-1:0] cur_sb;
    logic [63:0]        prod;
    logic [32:0]        zsq;

    if (i == 0) begin : g_first
      assign cur_v  = in_v;
      assign cur_z  = in_x;
      assign cur_f  = '0;
      assign cur_sb = in_sb;
    end else begin : g_next
      assign cur_v  = v_r[i-1];
      assign cur_z  = z_r[i-1];
      assign cur_f  = f_r[i-1];
      assign cur_sb = sb_r[i-1];
    end

    // square in Q1.31; reaching 2 yields a one bit of log2
    assign prod = 64'(cur_z) * 64'(cur_z);
    assign zsq  = prod[63:31];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        z_r[i]  <= zsq[32] ? zsq[32:1] : zsq[31:0];
        f_r[i]  <= {cur_f[30:0], zsq[32]};
        sb_r[i] <= cur_sb;
      end
    end
  end

  assign out_v    = v_r[LOG_STEPS-1];
  assign out_frac = f_r[LOG_STEPS-1];
  assign out_sb   = sb_r[LOG_STEPS-1];

endmodule

// ----- sv/pgs_div.sv -----
module pgs_div (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] in_num,
  input  logic [31:0] in_den,
  output logic [31:0] out_ratio
);
  import pgs_pkg::*;

  localparam logic [32:0] RATIO_MAX = 33'h0_8000_0000;

  logic [31:0] rem_r [DIV_STEPS];
  logic [32:0] nb_r  [DIV_STEPS];
  logic [32:0] quo_r [DIV_STEPS];
  logic [31:0] den_r [DIV_STEPS];
  logic [31:0] ratio_r;

  genvar i;
  for (i = 0; i < DIV_STEPS; i++) begin : g_step
    logic [31:0] cur_rem;
    logic [32:0] cur_nb;
    logic [32:0] cur_quo;
    logic [31:0] cur_den;
    logic [32:0] rem_sh;
    logic        fits;

    // dividend is num << 31; its top 30 bits start as the remainder
    if (i == 0) begin : g_first
      assign cur_rem = {2'b00, in_num[31:2]};
      assign cur_nb  = {in_num[1:0], 31'd0};
      assign cur_quo = '0;
      assign cur_den = in_den;
    end else begin : g_next
      assign cur_rem = rem_r[i-1];
      assign cur_nb  = nb_r[i-1];
      assign cur_quo = quo_r[i-1];
      assign cur_den = den_r[i-1];
    end

    assign rem_sh = {cur_rem, cur_nb[32]};
    assign fits   = rem_sh >= {1'b0, cur_den};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= 32'(fits ? rem_sh - {1'b0, cur_den} : rem_sh);
        nb_r[i]  <= {cur_nb[31:0], 1'b0};
        quo_r[i] <= {cur_quo[31:0], fits};
        den_r[i] <= cur_den;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ratio_r <= (quo_r[DIV_STEPS-1] > RATIO_MAX) ? RATIO_MAX[31:0]
                                                  : quo_r[DIV_STEPS-1][31:0];
    end
  end

  assign out_ratio = ratio_r;

endmodule

// ----- test/polar_gaussian_sampler_unit_checker.sv -----
module polar_gaussian_sampler_unit_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [31:0] in_uniform_a,
  input  logic [31:0] in_uniform_b,
  input  logic        out_valid,
  input  logic signed [31:0] out_normal_sample,
  input  logic        out_last_of_pair,
  output int          fail_count,
  output int          samples_waiting,
  output int          pairs_kept,
  output int          pairs_dropped
);

  typedef struct packed {
    logic signed [31:0] sample;
    logic               last;
  } deviate_t;

  deviate_t deviate_q[$];

  localparam logic [63:0] HALF_Q31 = 64'd1 << 31;
  localparam logic [63:0] ONE_Q62  = 64'd1 << 62;

  function automatic logic [63:0] root64(logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // sign and magnitude of 2u-1 in Q1.31
  function automatic logic [63:0] unit_mag(logic [31:0] u, output bit neg);
    logic [63:0] a;
    a = {32'd0, u};
    neg = (a < HALF_Q31);
    return neg ? HALF_Q31 - a : a - HALF_Q31;
  endfunction

  function automatic logic [63:0] minus_ln(logic [63:0] w);
    logic [63:0] z;
    logic [63:0] f;
    logic [63:0] a;
    logic [63:0] k;
    k = 0;
    f = 0;
    while (w < ONE_Q62) begin
      w = w << 1;
      k++;
    end
    z = w >> 31;
    for (int i = 31; i >= 0; i--) begin
      z = (z * z) >> 31;
      if (z >= (64'd1 << 32)) begin
        z = z >> 1;
        f[i] = 1'b1;
      end
    end
    a = (k << 32) - f;
    return (a >> 32) * {32'd0, pgs_pkg::LN2_Q32}
         + (({32'd0, a[31:0]} * {32'd0, pgs_pkg::LN2_Q32}) >> 32);
  endfunction

  // Q.59 magnitude to saturated Q4.28
  function automatic logic [31:0] to_q4_28(logic [63:0] mag, bit neg);
    logic [63:0] m;
    m = (mag + (64'd1 << 30)) >> 31;
    if (neg) begin
      if (m > HALF_Q31) m = HALF_Q31;
      return 32'(64'd0 - m);
    end
    if (m > HALF_Q31 - 1) m = HALF_Q31 - 1;
    return m[31:0];
  endfunction

  function automatic bit polar_pair(logic [31:0] ua, logic [31:0] ub,
                                    output logic [31:0] first, output logic [31:0] second);
    bit n1, n2;
    logic [63:0] m1, m2, w, s, wn, r, p1, p2;
    int j;
    m1 = unit_mag(ua, n1);
    m2 = unit_mag(ub, n2);
    w = m1 * m1 + m2 * m2;
    first = 0;
    second = 0;
    if (w == 0 || w >= ONE_Q62) return 0;
    s = root64(minus_ln(w) << 25);
    wn = w;
    j = 0;
    while (wn < (64'd1 << 61)) begin
      wn = wn << 2;
      j++;
    end
    r = root64(wn);
    p1 = ((m1 << j) << 31) / r;
    p2 = ((m2 << j) << 31) / r;
    if (p1 > HALF_Q31) p1 = HALF_Q31;
    if (p2 > HALF_Q31) p2 = HALF_Q31;
    first = to_q4_28(p2 * s, n2);
    second = to_q4_28(p1 * s, n1);
    return 1;
  endfunction

  assign samples_waiting = deviate_q.size();

  always @(posedge clk) begin
    logic [31:0] s0, s1;
    deviate_t got, want;
    if (!rst_n) begin
      fail_count <= 0;
      pairs_kept <= 0;
      pairs_dropped <= 0;
    end else begin
      if (start && !busy) begin
        if (polar_pair(in_uniform_a, in_uniform_b, s0, s1)) begin
          deviate_q.push_back('{sample: s0, last: 1'b0});
          deviate_q.push_back('{sample: s1, last: 1'b1});
          pairs_kept <= pairs_kept + 1;
        end else begin
          pairs_dropped <= pairs_dropped + 1;
        end
      end
      if (out_valid) begin
        got = '{sample: out_normal_sample, last: out_last_of_pair};
        if (deviate_q.size() == 0) begin
          $error("unexpected sample %0d", got.sample);
          fail_count <= fail_count + 1;
        end else begin
          want = deviate_q.pop_front();
          if (got.sample !== want.sample) begin
            $error("normal_sample expected %0d actual %0d", want.sample, got.sample);
            fail_count <= fail_count + 1;
          end else if (got.last !== want.last) begin
            $error("last_of_pair expected %0d actual %0d", want.last, got.last);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ----- test/polar_gaussian_sampler_unit_tb.sv -----
module polar_gaussian_sampler_unit_tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [31:0] in_uniform_a = '0;
  logic [31:0] in_uniform_b = '0;
  logic out_valid;
  logic signed [31:0] out_normal_sample;
  logic out_last_of_pair;
  int fail_count, samples_waiting, pairs_kept, pairs_dropped;
  int idle_pct;

  always #2 clk = ~clk;

  polar_gaussian_sampler_unit i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_uniform_a(in_uniform_a), .in_uniform_b(in_uniform_b),
    .out_valid(out_valid), .out_normal_sample(out_normal_sample),
    .out_last_of_pair(out_last_of_pair)
  );

  polar_gaussian_sampler_unit_checker i_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_uniform_a(in_uniform_a), .in_uniform_b(in_uniform_b),
    .out_valid(out_valid), .out_normal_sample(out_normal_sample),
    .out_last_of_pair(out_last_of_pair), .fail_count(fail_count),
    .samples_waiting(samples_waiting), .pairs_kept(pairs_kept),
    .pairs_dropped(pairs_dropped)
  );

  // busy only moves on the rising edge, so its value at the falling edge decides the transfer
  task automatic send_pair(logic [31:0] ua, logic [31:0] ub);
    @(negedge clk);
    start <= 1'b1;
    in_uniform_a <= ua;
    in_uniform_b <= ub;
    while (busy) @(negedge clk);
    @(posedge clk);
    // each cycle after a transfer stays idle with chance idle_pct percent
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      in_uniform_a <= $urandom;
      in_uniform_b <= $urandom;
      while ($urandom_range(99) < idle_pct) @(negedge clk);
    end
  endtask

  // uniforms near the center give w near zero
  function automatic logic [31:0] near_center();
    return 32'h8000_0000 + 32'($signed($urandom_range(2000)) - 1000);
  endfunction

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    idle_pct = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero w, corners at w >= 1, near-unit w, tiny w with saturation of both signs
    send_pair(32'h8000_0000, 32'h8000_0000);
    send_pair(32'h0000_0000, 32'h0000_0000);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pair(32'h0000_0000, 32'h8000_0000);
    send_pair(32'h8000_0000, 32'h0000_0000);
    send_pair(32'hFFFF_FFFF, 32'h8000_0000);
    send_pair(32'h8000_0000, 32'hFFFF_FFFF);
    send_pair(32'h8000_0001, 32'h8000_0000);
    send_pair(32'h7FFF_FFFF, 32'h8000_0000);
    send_pair(32'h8000_0000, 32'h8000_0001);
    send_pair(32'h8000_0000, 32'h7FFF_FFFF);
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_pair(32'h8000_0001, 32'h8000_0001);
    send_pair(32'hDA82_7999, 32'hDA82_7999);
    send_pair(32'h257D_8667, 32'h257D_8667);
    send_pair(32'hC000_0000, 32'h4000_0000);
    send_pair(32'h5555_5555, 32'hAAAA_AAAA);
    send_pair(32'h8000_1000, 32'h7FFF_F000);

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1) ? 82 : (phase == 3) ? 26 : 0;
      for (int n = 0; n < 385; n++) begin
        case ($urandom_range(9))
          0: send_pair(near_center(), near_center());
          1: send_pair($urandom, near_center());
          default: send_pair($urandom, $urandom);
        endcase
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (samples_waiting != 0) @(posedge clk);
    repeat (120) @(posedge clk);

    $display("pairs sent: %0d kept, %0d dropped; idle mixes 0, 82 and 26 percent",
             pairs_kept, pairs_dropped);
    if (fail_count == 0 && samples_waiting == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
